FILE: src/int8_matrix_multiply_assert.svh
// ---------------------------------------------------------------------------
// int8_matrix_multiply assertion macros
// Shared concurrent assertion forms used by the RTL of the matrix multiplier.
// ---------------------------------------------------------------------------
`ifndef INT8_MATRIX_MULTIPLY_ASSERT_SVH
`define INT8_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMM_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/imm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_pkg
// Types and constants shared by the int8 matrix multiplier modules.
// ---------------------------------------------------------------------------
package imm_pkg;

    localparam int REG_IDX_W  = 1;
    localparam int REG_DATA_W = 9;
    localparam int K_SIZE_W   = 9;
    localparam int N_SIZE_W   = 6;
    localparam int ACC_W      = 24;
    localparam int PROD_W     = 16;

    localparam logic [REG_IDX_W-1:0] REG_K_SIZE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_N_SIZE = 1'd1;

    localparam logic [K_SIZE_W-1:0] K_SIZE_RESET = 9'd256;
    localparam logic [N_SIZE_W-1:0] N_SIZE_RESET = 6'd32;

    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_ACT    = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [7:0]        inner_index;
        logic [4:0]        column_index;
        logic signed [7:0] element_value;
    } t_in;

    typedef struct packed {
        logic [4:0]         result_column;
        logic signed [23:0] dot_value;
        logic               last_of_row;
    } t_out;

    // Command passed from the front end to the back end through the queue.
    typedef struct packed {
        logic                load;
        logic [7:0]          inner;
        logic [4:0]          column;
        logic signed [7:0]   value;
        logic                close;
        logic [N_SIZE_W-1:0] ncols;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } t_back_state;

endpackage

FILE: src/imm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module imm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/imm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_front
// Accepts items, classifies them and queues the commands for the back end.
// ---------------------------------------------------------------------------
module imm_front #(
    parameter int MAX_INNER   = 256,
    parameter int MAX_COLUMNS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  imm_pkg::t_in                   i_item,
    input  logic [imm_pkg::K_SIZE_W-1:0]   i_k_size,
    input  logic [imm_pkg::N_SIZE_W-1:0]   i_n_size,
    input  logic                           i_pop,
    output logic                           o_q_valid,
    output imm_pkg::t_cmd                  o_q_head
);

    localparam int KEW = ($clog2(MAX_INNER + 1) > imm_pkg::K_SIZE_W) ?
                         $clog2(MAX_INNER + 1) : imm_pkg::K_SIZE_W;
    localparam int CEW = ($clog2(MAX_COLUMNS + 1) > imm_pkg::N_SIZE_W) ?
                         $clog2(MAX_COLUMNS + 1) : imm_pkg::N_SIZE_W;
    localparam int QD  = 4;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    logic [KEW-1:0]                 w_inner_ext;
    logic [KEW-1:0]                 w_k_last;
    logic [CEW-1:0]                 w_col_ext;
    logic [CEW-1:0]                 w_n_ext;
    logic [imm_pkg::N_SIZE_W-1:0]   w_ncols;
    logic                           w_inner_ok;
    logic                           w_col_ok;
    logic                           w_close;
    logic                           w_keep;
    logic                           w_push;
    imm_pkg::t_cmd                  w_cmd;

    imm_pkg::t_cmd                  r_q [QD];
    logic [QAW-1:0]                 r_wp;
    logic [QAW-1:0]                 r_rp;
    logic [QCW-1:0]                 r_cnt;
    logic [QCW-1:0]                 n_cnt;

    // Classify: resolve effective sizes, drop items that touch nothing.
    always_comb begin
        w_inner_ext = KEW'(i_item.inner_index);
        w_col_ext   = CEW'(i_item.column_index);
        w_n_ext     = CEW'(i_n_size);
        w_inner_ok  = (w_inner_ext < KEW'(MAX_INNER));
        w_col_ok    = (w_col_ext < CEW'(MAX_COLUMNS));

        if (i_k_size == '0) begin
            w_k_last = '0;
        end else if (KEW'(i_k_size) > KEW'(MAX_INNER)) begin
            w_k_last = KEW'(MAX_INNER - 1);
        end else begin
            w_k_last = KEW'(i_k_size) - KEW'(1);
        end

        if (i_n_size == '0) begin
            w_ncols = imm_pkg::N_SIZE_W'(1);
        end else if (w_n_ext > CEW'(MAX_COLUMNS)) begin
            w_ncols = imm_pkg::N_SIZE_W'(MAX_COLUMNS);
        end else begin
            w_ncols = i_n_size;
        end

        w_close = (i_item.mode == imm_pkg::MODE_ACT) && (w_inner_ext == w_k_last);
        if (i_item.mode == imm_pkg::MODE_WEIGHT) begin
            w_keep = w_inner_ok && w_col_ok;
        end else begin
            w_keep = w_inner_ok;
        end

        w_cmd.load   = (i_item.mode == imm_pkg::MODE_WEIGHT);
        w_cmd.inner  = i_item.inner_index;
        w_cmd.column = i_item.column_index;
        w_cmd.value  = i_item.element_value;
        w_cmd.close  = w_close;
        w_cmd.ncols  = w_ncols;
    end

    assign o_busy    = (r_cnt == QCW'(QD));
    assign w_push    = i_start && !o_busy && w_keep;
    assign n_cnt     = r_cnt + QCW'(w_push) - QCW'(i_pop);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

FILE: src/imm_back.sv
`timescale 1ns / 1ps
`include "int8_matrix_multiply_assert.svh"
// ---------------------------------------------------------------------------
// imm_back
// Executes queued commands: weight writes and per-column multiply-accumulate.
// ---------------------------------------------------------------------------
module imm_back #(
    parameter int MAX_INNER   = 256,
    parameter int MAX_COLUMNS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  imm_pkg::t_cmd  i_q_head,
    output logic           o_pop,
    output logic           o_strobe,
    output imm_pkg::t_out  o_result
);

    localparam int KW  = ($clog2(MAX_INNER) > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CW  = ($clog2(MAX_COLUMNS) > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int AD  = 2 ** CW;
    localparam int WD  = 2 ** (KW + CW);
    localparam int NW  = imm_pkg::N_SIZE_W;

    imm_pkg::t_back_state           r_state;
    imm_pkg::t_back_state           n_state;
    imm_pkg::t_cmd                  r_cmd;
    logic [NW-1:0]                  r_cnt;

    logic                           r_p1_vld;
    logic [NW-1:0]                  r_p1_col;
    logic                           r_p1_last;
    logic                           r_p2_vld;
    logic [NW-1:0]                  r_p2_col;
    logic                           r_p2_last;
    logic signed [imm_pkg::PROD_W-1:0] r_p2_prod;
    logic [imm_pkg::ACC_W-1:0]      r_p2_acc;
    logic [AD-1:0]                  r_acc_vld;

    logic                           r_out_vld;
    imm_pkg::t_out                  r_out;

    logic                           w_wr_weight;
    logic                           w_issue;
    logic                           w_clear;
    logic                           w_pipe_empty;
    logic [7:0]                     w_w_rdata;
    logic [imm_pkg::ACC_W-1:0]      w_a_rdata;
    logic signed [imm_pkg::PROD_W-1:0] w_prod;
    logic [imm_pkg::ACC_W-1:0]      w_sum;

    assign w_pipe_empty = !r_p1_vld && !r_p2_vld;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            imm_pkg::ST_IDLE: begin
                if (i_q_valid && !i_q_head.load) begin
                    n_state = imm_pkg::ST_SWEEP;
                end
            end
            imm_pkg::ST_SWEEP: begin
                if (r_cnt == r_cmd.ncols - NW'(1)) begin
                    n_state = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN: begin
                if (w_pipe_empty) begin
                    n_state = imm_pkg::ST_IDLE;
                end
            end
            default: n_state = imm_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop   = 1'b0;
        w_issue = 1'b0;
        w_clear = 1'b0;
        case (r_state)
            imm_pkg::ST_IDLE:  o_pop   = i_q_valid;
            imm_pkg::ST_SWEEP: w_issue = 1'b1;
            imm_pkg::ST_DRAIN: w_clear = w_pipe_empty && r_cmd.close;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign w_wr_weight = o_pop && i_q_head.load;

    imm_ram #(
        .WIDTH (8),
        .DEPTH (WD)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_weight),
        .i_waddr ({KW'(i_q_head.inner), CW'(i_q_head.column)}),
        .i_wdata (i_q_head.value),
        .i_raddr ({KW'(r_cmd.inner), CW'(r_cnt)}),
        .o_rdata (w_w_rdata)
    );

    imm_ram #(
        .WIDTH (imm_pkg::ACC_W),
        .DEPTH (AD)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_p2_vld),
        .i_waddr (CW'(r_p2_col)),
        .i_wdata (w_sum),
        .i_raddr (CW'(r_cnt)),
        .o_rdata (w_a_rdata)
    );

    assign w_prod = r_cmd.value * $signed(w_w_rdata);
    assign w_sum  = r_p2_acc + imm_pkg::ACC_W'(r_p2_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= imm_pkg::ST_IDLE;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_p1_vld  <= w_issue;
            r_p2_vld  <= r_p1_vld;
            r_out_vld <= r_p2_vld && r_cmd.close;
            if (w_clear) begin
                r_acc_vld <= '0;
            end else if (r_p2_vld) begin
                r_acc_vld[CW'(r_p2_col)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_q_head.load) begin
            r_cmd <= i_q_head;
            r_cnt <= '0;
        end else if (w_issue) begin
            r_cnt <= r_cnt + NW'(1);
        end
        r_p1_col  <= r_cnt;
        r_p1_last <= (r_cnt == r_cmd.ncols - NW'(1));
        r_p2_col  <= r_p1_col;
        r_p2_last <= r_p1_last;
        r_p2_prod <= w_prod;
        r_p2_acc  <= r_acc_vld[CW'(r_p1_col)] ? w_a_rdata : '0;
        r_out.result_column <= r_p2_col[4:0];
        r_out.dot_value     <= w_sum;
        r_out.last_of_row   <= r_p2_last;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    `IMM_ASSERT_HOLDS(a_sweep_in_range, i_clk, i_rst_n, r_state == imm_pkg::ST_SWEEP, r_cnt < r_cmd.ncols, "column counter ran past the column count")
    `IMM_ASSERT_HOLDS(a_acc_no_collide, i_clk, i_rst_n, (r_state == imm_pkg::ST_SWEEP) && r_p2_vld, r_p2_col != r_cnt, "accumulator read and write hit one column")
    `IMM_ASSERT_NEXT(a_last_ends_row, i_clk, i_rst_n, r_out_vld && r_out.last_of_row, !r_out_vld, "result followed the last column of a row")
    `IMM_ASSERT_NEXT(a_row_clears_acc, i_clk, i_rst_n, w_clear, r_acc_vld == '0, "accumulators not cleared after a row")

endmodule

FILE: src/int8_matrix_multiply.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// int8_matrix_multiply
// Signed int8 activation rows times a stored int8 weight matrix, exact sums.
// ---------------------------------------------------------------------------
// Drive start with an item whenever busy is low; the item is taken at that
// edge. A four-entry command queue sits between the intake and the execution
// engine, so busy only rises when that queue is full. A weight load is written
// to the store as the engine takes it from the queue. An activation item
// holds the engine for its column sweep: it has one shared 8x8 multiplier and
// one accumulator RAM, and walks the columns one per cycle, followed by a short
// pipeline drain. When an activation closes a row (index k_size-1), its n_size
// results leave on o_strobe / o_result, one per cycle in column order, once the
// first column has passed the RAM reads, the product stage and the result
// register, with last_of_row on the final column. Results cannot be held off:
// sample them on every cycle o_strobe is high. Weight and activation items
// whose index lies outside the store are dropped at intake. Write the size registers only while the block is idle.
// ---------------------------------------------------------------------------
module int8_matrix_multiply #(
    parameter int MAX_INNER   = 256,
    parameter int MAX_COLUMNS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  imm_pkg::t_in                     i_item,
    input  logic                             i_cfg_we,
    input  logic [imm_pkg::REG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imm_pkg::REG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_strobe,
    output imm_pkg::t_out                    o_result
);

    logic [imm_pkg::K_SIZE_W-1:0] r_k_size;
    logic [imm_pkg::N_SIZE_W-1:0] r_n_size;

    logic           w_q_valid;
    logic           w_pop;
    imm_pkg::t_cmd  w_q_head;

    // Size registers: latch on write enable, no handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_size <= imm_pkg::K_SIZE_RESET;
            r_n_size <= imm_pkg::N_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                imm_pkg::REG_K_SIZE: r_k_size <= i_cfg_data[imm_pkg::K_SIZE_W-1:0];
                imm_pkg::REG_N_SIZE: r_n_size <= i_cfg_data[imm_pkg::N_SIZE_W-1:0];
                default: begin
                    r_k_size <= r_k_size;
                end
            endcase
        end
    end

    // Intake: classify each item and queue it for the engine.
    imm_front #(
        .MAX_INNER   (MAX_INNER),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_item    (i_item),
        .i_k_size  (r_k_size),
        .i_n_size  (r_n_size),
        .i_pop     (w_pop),
        .o_q_valid (w_q_valid),
        .o_q_head  (w_q_head)
    );

    // Engine: weight store, column sweep, accumulators and result register.
    imm_back #(
        .MAX_INNER   (MAX_INNER),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_q_head),
        .o_pop     (w_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

FILE: test/imm_dot_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imm_dot_checker
// Watches the item, register and result ports of the matrix multiplier and
// predicts every dot product from its own copy of the weights and column sums.
// ---------------------------------------------------------------------------
module imm_dot_checker
    import imm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_in                   i_item,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [REG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_strobe,
    input  t_out                  i_result,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int ROWS = 256;
    localparam int COLS = 32;

    logic signed [7:0]   weights  [0:ROWS-1][0:COLS-1];
    logic [ACC_W-1:0]    col_sums [0:COLS-1];
    logic [K_SIZE_W-1:0] k_size;
    logic [N_SIZE_W-1:0] n_size;
    t_out                owed_dots [$];
    int                  errors;

    always @(posedge i_clk) begin
        t_out               want;
        logic signed [15:0] prod;
        int                 k_lim;
        int                 n_lim;
        if (!i_rst_n) begin
            k_size = K_SIZE_RESET;
            n_size = N_SIZE_RESET;
            for (int c = 0; c < COLS; c++) col_sums[c] = '0;
            owed_dots.delete();
            errors = 0;
        end else begin
            if (i_strobe) begin
                if (owed_dots.size() == 0) begin
                    errors++;
                    $display("%0t: col/dot/last expected none, got %0d/%0d/%0b",
                             $time, i_result.result_column, i_result.dot_value,
                             i_result.last_of_row);
                end else begin
                    want = owed_dots.pop_front();
                    if (i_result !== want) begin
                        errors++;
                        $display("%0t: col/dot/last expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 $time, want.result_column, want.dot_value,
                                 want.last_of_row, i_result.result_column,
                                 i_result.dot_value, i_result.last_of_row);
                    end
                end
            end

            if (i_cfg_we) begin
                if (i_cfg_idx == REG_K_SIZE) k_size = i_cfg_data[K_SIZE_W-1:0];
                else if (i_cfg_idx == REG_N_SIZE) n_size = i_cfg_data[N_SIZE_W-1:0];
            end

            if (i_start && !i_busy) begin
                k_lim = (k_size == 0) ? 1 : ((k_size > ROWS) ? ROWS : int'(k_size));
                n_lim = (n_size == 0) ? 1 : ((n_size > COLS) ? COLS : int'(n_size));
                if (i_item.mode == MODE_WEIGHT) begin
                    weights[i_item.inner_index][i_item.column_index] = i_item.element_value;
                end else begin
                    for (int c = 0; c < n_lim; c++) begin
                        prod = i_item.element_value * weights[i_item.inner_index][c];
                        col_sums[c] = col_sums[c] + {{(ACC_W-16){prod[15]}}, prod};
                    end
                    if (int'(i_item.inner_index) == k_lim - 1) begin
                        for (int c = 0; c < n_lim; c++) begin
                            want.result_column = 5'(c);
                            want.dot_value     = col_sums[c];
                            want.last_of_row   = (c == n_lim - 1);
                            owed_dots.push_back(want);
                        end
                        for (int c = 0; c < COLS; c++) col_sums[c] = '0;
                    end
                end
            end
        end
        o_errors  <= errors;
        o_pending <= owed_dots.size();
    end

endmodule

FILE: test/tb_int8_matrix_multiply.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_int8_matrix_multiply
// Drives weight loads and activation rows into the int8 matrix multiplier
// under changing inner and column sizes; a side checker predicts each dot
// product and this top reports the verdict.
// ---------------------------------------------------------------------------
module tb_int8_matrix_multiply;
    import imm_pkg::*;

    // Enough for a full command queue of the widest activations to drain.
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 360;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in                   i_item;
    logic                  i_cfg_we;
    logic [REG_IDX_W-1:0]  i_cfg_idx;
    logic [REG_DATA_W-1:0] i_cfg_data;
    logic                  o_strobe;
    t_out                  o_result;

    int mismatches;
    int results_owed;
    int cycle_count = 0;
    int items_sent  = 0;

    // Effective sizes as the stimulus sees them, used to plan rows.
    int k_eff;
    int n_eff;
    // Weights written so far; an activation never reads a hole in the store.
    bit loaded [0:255][0:31];

    int8_matrix_multiply dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    imm_dot_checker u_dot_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_strobe   (o_strobe),
        .i_result   (o_result),
        .o_errors   (mismatches),
        .o_pending  (results_owed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or results go missing.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Lean toward the extremes of the signed range.
    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 8'h80;
            1: return 8'h7f;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. The sender idles
    // now and then, except over a long stretch in the middle of the run.
    task automatic send_item(input t_in it);
        while ((items_sent < 150 || items_sent >= 260) && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (it.mode == MODE_WEIGHT) loaded[it.inner_index][it.column_index] = 1'b1;
    endtask

    task automatic load_weight(input int k, input int j, input logic [7:0] v);
        t_in it;
        it.mode          = MODE_WEIGHT;
        it.inner_index   = 8'(k);
        it.column_index  = 5'(j);
        it.element_value = v;
        send_item(it);
    endtask

    // Fill any missing weight of row k in the active columns first, then send
    // the activation element itself.
    task automatic send_act(input int k, input logic [7:0] v);
        t_in it;
        for (int c = 0; c < n_eff; c++)
            if (!loaded[k][c]) load_weight(k, c, pick_value());
        it.mode          = MODE_ACT;
        it.inner_index   = 8'(k);
        it.column_index  = 5'($urandom_range(0, 31));
        it.element_value = v;
        send_item(it);
    endtask

    // Drop start, wait for every owed result, then let the engine go quiet.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both size registers on back-to-back cycles; only call when idle.
    task automatic set_sizes(input int k_reg, input int n_reg);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_K_SIZE;
        i_cfg_data <= REG_DATA_W'(k_reg);
        @(posedge i_clk);
        i_cfg_idx  <= REG_N_SIZE;
        i_cfg_data <= REG_DATA_W'(n_reg);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        k_eff = (k_reg == 0) ? 1 : ((k_reg > 256) ? 256 : k_reg);
        n_eff = (n_reg == 0) ? 1 : ((n_reg > 32) ? 32 : n_reg);
    endtask

    initial begin
        int k_reg;
        int n_reg;
        int first_random;
        int last_shuffled;
        int pick;
        int tmp;
        int order [0:255];

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_K_SIZE;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero sizes act as one: every activation at index zero closes a row.
        set_sizes(0, 0);
        load_weight(0, 0, 8'h80);
        load_weight(0, 31, 8'h7f);
        load_weight(255, 0, 8'h7f);
        send_act(0, 8'h80);
        send_act(0, 8'h7f);
        // Index above the row end: accumulates but does not close.
        send_act(255, 8'h01);
        send_act(0, 8'h00);
        settle();

        // The oversized inner size clamps to the full store; close on the top index,
        // with a repeated index along the way.
        set_sizes(511, 63);
        set_sizes(511, 2);
        load_weight(0, 1, 8'hff);
        load_weight(255, 1, 8'h80);
        send_act(0, 8'h05);
        send_act(0, 8'hff);
        send_act(255, 8'h80);
        settle();

        // Change sizes in the middle of a row; partial sums must survive.
        set_sizes(3, 1);
        send_act(0, 8'h03);
        settle();
        set_sizes(1, 2);
        send_act(0, 8'hfe);
        settle();

        // Random phases: each picks sizes, then streams rows of activations.
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       k_reg = 0;
                1:       k_reg = $urandom_range(33, 511);
                2:       k_reg = $urandom_range(9, 32);
                default: k_reg = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       n_reg = 0;
                1:       n_reg = 32;
                2:       n_reg = $urandom_range(33, 63);
                default: n_reg = $urandom_range(1, 8);
            endcase
            set_sizes(k_reg, n_reg);

            if (k_eff > 32) begin
                // Large inner size: a few scattered elements, then the closing one.
                repeat ($urandom_range(2, 6)) send_act($urandom_range(0, k_eff - 2), pick_value());
                send_act(k_eff - 1, pick_value());
            end else begin
                repeat ($urandom_range(2, 5)) begin
                    for (int i = 0; i < k_eff; i++) order[i] = i;
                    // Keep the closing index last, except for the odd broken row.
                    last_shuffled = ($urandom_range(0, 9) == 0) ? k_eff : k_eff - 1;
                    for (int i = last_shuffled - 1; i > 0; i--) begin
                        pick = $urandom_range(0, i);
                        tmp = order[i];
                        order[i] = order[pick];
                        order[pick] = tmp;
                    end
                    for (int i = 0; i < k_eff; i++) begin
                        // Sprinkle stray weight writes, out-of-row indices and repeats.
                        case ($urandom_range(0, 19))
                            0, 1: load_weight($urandom_range(0, 255), $urandom_range(0, 31),
                                              pick_value());
                            2: if (k_eff < 256) send_act($urandom_range(k_eff, 255), pick_value());
                            3: if (i > 0) send_act(order[$urandom_range(0, i - 1)], pick_value());
                            default: ;
                        endcase
                        send_act(order[i], pick_value());
                    end
                end
            end
            settle();
        end

        settle();
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

FILE: int8_matrix_multiply.f
+incdir+src
src/imm_pkg.sv
src/imm_ram.sv
src/imm_front.sv
src/imm_back.sv
src/int8_matrix_multiply.sv
test/imm_dot_checker.sv
test/tb_int8_matrix_multiply.sv
